FILE: hdl/cllm_pkg.sv
`default_nettype none

package cllm_pkg;

    // Defaults for the top-level parameters
    localparam int SPACE_SIZE_DEF = 64;
    localparam int KEY_BITS_DEF   = 64;

    // Fixed field widths of the stream payload
    localparam int CMD_BITS    = 3;
    localparam int POS_BITS    = 6;
    localparam int STATUS_BITS = 2;
    localparam int IN_KEY_BITS = 64;

    // Command codes
    localparam logic [CMD_BITS-1:0] CMD_CREATE = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_APPEND = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_DELETE = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_FIND   = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_EMPTY  = 3'd5;

    // Status codes
    localparam logic [STATUS_BITS-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] STAT_NO_SPACE  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STAT_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic                  list_empty;
        logic [POS_BITS-1:0]   position;
        logic [STATUS_BITS-1:0] status;
    } t_result;

endpackage

`default_nettype wire

FILE: hdl/cllm_store.sv
`default_nettype none

// Link and key memories: one write port each, one shared read address,
// read data registered (read-old on a same-address write).
module cllm_store #(
    parameter int SPACE_SIZE = cllm_pkg::SPACE_SIZE_DEF,
    parameter int KEY_BITS   = cllm_pkg::KEY_BITS_DEF,
    localparam int IW = (SPACE_SIZE > 1) ? $clog2(SPACE_SIZE) : 1
) (
    input  wire logic                i_clk,
    input  wire logic [IW-1:0]       i_rd_addr,
    output      logic [IW-1:0]       o_rd_link,
    output      logic [KEY_BITS-1:0] o_rd_key,
    input  wire logic                i_lw_en,
    input  wire logic [IW-1:0]       i_lw_addr,
    input  wire logic [IW-1:0]       i_lw_data,
    input  wire logic                i_kw_en,
    input  wire logic [IW-1:0]       i_kw_addr,
    input  wire logic [KEY_BITS-1:0] i_kw_data
);

    logic [IW-1:0]       link_mem [SPACE_SIZE];
    logic [KEY_BITS-1:0] key_mem  [SPACE_SIZE];

    always_ff @(posedge i_clk) begin
        if (i_lw_en) begin
            link_mem[i_lw_addr] <= i_lw_data;
        end
        o_rd_link <= link_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_kw_en) begin
            key_mem[i_kw_addr] <= i_kw_data;
        end
        o_rd_key <= key_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

FILE: hdl/cllm_ctrl.sv
`default_nettype none

// Command sequencer: walks chains through the store, one read per step.
// Keeps a shadow copy of the free-list head (link of cell 0).
module cllm_ctrl #(
    parameter int SPACE_SIZE = cllm_pkg::SPACE_SIZE_DEF,
    parameter int KEY_BITS   = cllm_pkg::KEY_BITS_DEF,
    localparam int IW = (SPACE_SIZE > 1) ? $clog2(SPACE_SIZE) : 1
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // command side
    input  wire logic                              i_req_valid,
    output      logic                              o_req_ready,
    input  wire logic [cllm_pkg::CMD_BITS-1:0]     i_cmd,
    input  wire logic [IW-1:0]                     i_head,
    input  wire logic [IW-1:0]                     i_pos,
    input  wire logic [KEY_BITS-1:0]               i_key,
    // result side
    output      logic                              o_res_valid,
    input  wire logic                              i_res_ready,
    output      cllm_pkg::t_result                 o_res,
    // store
    output      logic [IW-1:0]                     o_rd_addr,
    input  wire logic [IW-1:0]                     i_rd_link,
    input  wire logic [KEY_BITS-1:0]               i_rd_key,
    output      logic                              o_lw_en,
    output      logic [IW-1:0]                     o_lw_addr,
    output      logic [IW-1:0]                     o_lw_data,
    output      logic                              o_kw_en,
    output      logic [IW-1:0]                     o_kw_addr,
    output      logic [KEY_BITS-1:0]               o_kw_data
);

    localparam int SW = IW + 1;
    localparam logic [IW-1:0] LAST_CELL = IW'(SPACE_SIZE - 1);
    localparam logic [SW-1:0] STEP_MAX  = SW'(SPACE_SIZE);

    localparam logic [4:0] S_INIT     = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_TAKE     = 5'd2;
    localparam logic [4:0] S_TAKE_NX  = 5'd3;
    localparam logic [4:0] S_CRT_WR   = 5'd4;
    localparam logic [4:0] S_PLC_RD   = 5'd5;
    localparam logic [4:0] S_PLC_WR1  = 5'd6;
    localparam logic [4:0] S_PLC_WR2  = 5'd7;
    localparam logic [4:0] S_WALK_RD  = 5'd8;
    localparam logic [4:0] S_WALK_CHK = 5'd9;
    localparam logic [4:0] S_DEL_RD   = 5'd10;
    localparam logic [4:0] S_DEL_CHK  = 5'd11;
    localparam logic [4:0] S_DEL_CMP  = 5'd12;
    localparam logic [4:0] S_GIVE_A   = 5'd13;
    localparam logic [4:0] S_GIVE_B   = 5'd14;
    localparam logic [4:0] S_FIND_RD  = 5'd15;
    localparam logic [4:0] S_FIND_CHK = 5'd16;
    localparam logic [4:0] S_FIND_CMP = 5'd17;
    localparam logic [4:0] S_EMP_RD   = 5'd18;
    localparam logic [4:0] S_EMP_CLR  = 5'd19;
    localparam logic [4:0] S_EMP_LOOP = 5'd20;
    localparam logic [4:0] S_EMP_FREE = 5'd21;
    localparam logic [4:0] S_EMP_LINK = 5'd22;
    localparam logic [4:0] S_HEAD_RD  = 5'd23;
    localparam logic [4:0] S_HEAD_CHK = 5'd24;
    localparam logic [4:0] S_DONE     = 5'd25;

    logic [4:0]                          r_state, n_state;
    logic [cllm_pkg::CMD_BITS-1:0]       r_cmd, n_cmd;
    logic [IW-1:0]                       r_head, n_head;
    logic [KEY_BITS-1:0]                 r_key, n_key;
    logic [IW-1:0]                       r_p, n_p;
    logic [IW-1:0]                       r_c, n_c;
    logic [SW-1:0]                       r_steps, n_steps;
    logic [cllm_pkg::STATUS_BITS-1:0]    r_status, n_status;
    logic [IW-1:0]                       r_res, n_res;
    logic                                r_empty, n_empty;
    logic [IW-1:0]                       r_free, n_free;
    logic [IW-1:0]                       r_init, n_init;
    logic [SW-1:0]                       steps_inc;

    assign steps_inc   = SW'(r_steps + SW'(1));
    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res.status     = r_status;
        o_res.position   = cllm_pkg::POS_BITS'(r_res);
        o_res.list_empty = r_empty;
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_head    = r_head;
        n_key     = r_key;
        n_p       = r_p;
        n_c       = r_c;
        n_steps   = r_steps;
        n_status  = r_status;
        n_res     = r_res;
        n_empty   = r_empty;
        n_init    = r_init;
        o_rd_addr = r_p;
        o_lw_en   = 1'b0;
        o_lw_addr = r_p;
        o_lw_data = '0;
        o_kw_en   = 1'b0;
        o_kw_addr = r_free;
        o_kw_data = r_key;

        unique case (r_state)
            S_INIT: begin
                // sweep: cell i links to i+1, last cell to 0
                o_lw_en   = 1'b1;
                o_lw_addr = r_init;
                o_lw_data = (r_init == LAST_CELL) ? '0 : IW'(r_init + IW'(1));
                n_init    = IW'(r_init + IW'(1));
                if (r_init == LAST_CELL) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_cmd    = i_cmd;
                    n_head   = i_head;
                    n_key    = i_key;
                    n_p      = (i_cmd == cllm_pkg::CMD_INSERT) ? i_pos : i_head;
                    n_steps  = '0;
                    n_status = cllm_pkg::STAT_OK;
                    n_res    = '0;
                    n_empty  = 1'b1;
                    unique case (i_cmd)
                        cllm_pkg::CMD_CREATE: n_state = S_TAKE;
                        cllm_pkg::CMD_INSERT: n_state = S_TAKE;
                        cllm_pkg::CMD_APPEND: n_state = S_WALK_RD;
                        cllm_pkg::CMD_DELETE: begin
                            n_status = cllm_pkg::STAT_NOT_FOUND;
                            n_state  = S_DEL_RD;
                        end
                        cllm_pkg::CMD_FIND: begin
                            n_status = cllm_pkg::STAT_NOT_FOUND;
                            n_state  = S_FIND_RD;
                        end
                        cllm_pkg::CMD_EMPTY: n_state = S_EMP_RD;
                        default:             n_state = S_HEAD_RD;
                    endcase
                end
            end
            // take the free-list head
            S_TAKE: begin
                if (r_free == '0) begin
                    n_status = cllm_pkg::STAT_NO_SPACE;
                    n_state  = (r_cmd == cllm_pkg::CMD_CREATE) ? S_DONE : S_HEAD_RD;
                end else begin
                    n_c       = r_free;
                    o_rd_addr = r_free;
                    o_kw_en   = (r_cmd != cllm_pkg::CMD_CREATE);
                    n_state   = S_TAKE_NX;
                end
            end
            S_TAKE_NX: begin
                o_lw_en   = 1'b1;
                o_lw_addr = '0;
                o_lw_data = i_rd_link;
                n_res     = r_c;
                n_state   = (r_cmd == cllm_pkg::CMD_CREATE) ? S_CRT_WR : S_PLC_RD;
            end
            S_CRT_WR: begin
                o_lw_en   = 1'b1;
                o_lw_addr = r_c;
                o_lw_data = '0;
                n_state   = S_DONE;
            end
            // link new cell c after p
            S_PLC_RD: begin
                o_rd_addr = r_p;
                n_state   = S_PLC_WR1;
            end
            S_PLC_WR1: begin
                o_lw_en   = 1'b1;
                o_lw_addr = r_c;
                o_lw_data = i_rd_link;
                n_state   = S_PLC_WR2;
            end
            S_PLC_WR2: begin
                o_lw_en   = 1'b1;
                o_lw_addr = r_p;
                o_lw_data = r_c;
                n_state   = S_HEAD_RD;
            end
            // append: find the tail
            S_WALK_RD: begin
                o_rd_addr = r_p;
                n_state   = S_WALK_CHK;
            end
            S_WALK_CHK: begin
                if (i_rd_link == '0) begin
                    n_state = S_TAKE;
                end else begin
                    n_p       = i_rd_link;
                    n_steps   = steps_inc;
                    o_rd_addr = i_rd_link;
                    if (steps_inc == STEP_MAX) begin
                        n_state = S_TAKE;
                    end
                end
            end
            // delete: p trails c
            S_DEL_RD: begin
                o_rd_addr = r_p;
                n_state   = S_DEL_CHK;
            end
            S_DEL_CHK: begin
                if (i_rd_link == '0) begin
                    n_state = S_HEAD_RD;
                end else begin
                    n_c       = i_rd_link;
                    o_rd_addr = i_rd_link;
                    n_state   = S_DEL_CMP;
                end
            end
            S_DEL_CMP: begin
                if (i_rd_key == r_key) begin
                    o_lw_en   = 1'b1;
                    o_lw_addr = r_p;
                    o_lw_data = i_rd_link;
                    n_status  = cllm_pkg::STAT_OK;
                    n_res     = r_c;
                    n_state   = S_GIVE_A;
                end else begin
                    n_p     = r_c;
                    n_steps = steps_inc;
                    if (steps_inc == STEP_MAX || i_rd_link == '0) begin
                        n_state = S_HEAD_RD;
                    end else begin
                        n_c       = i_rd_link;
                        o_rd_addr = i_rd_link;
                    end
                end
            end
            // return cell c to the free list
            S_GIVE_A: begin
                o_lw_en   = 1'b1;
                o_lw_addr = r_c;
                o_lw_data = r_free;
                n_state   = S_GIVE_B;
            end
            S_GIVE_B: begin
                o_lw_en   = 1'b1;
                o_lw_addr = '0;
                o_lw_data = r_c;
                n_state   = S_HEAD_RD;
            end
            // find: p is the cell under test
            S_FIND_RD: begin
                o_rd_addr = r_p;
                n_state   = S_FIND_CHK;
            end
            S_FIND_CHK: begin
                if (i_rd_link == '0) begin
                    n_state = S_HEAD_RD;
                end else begin
                    n_p       = i_rd_link;
                    o_rd_addr = i_rd_link;
                    n_state   = S_FIND_CMP;
                end
            end
            S_FIND_CMP: begin
                if (i_rd_key == r_key) begin
                    n_status = cllm_pkg::STAT_OK;
                    n_res    = r_p;
                    n_state  = S_HEAD_RD;
                end else begin
                    n_p     = i_rd_link;
                    n_steps = steps_inc;
                    if (steps_inc == STEP_MAX || i_rd_link == '0) begin
                        n_state = S_HEAD_RD;
                    end else begin
                        o_rd_addr = i_rd_link;
                    end
                end
            end
            // make empty: detach the chain, then free cell by cell
            S_EMP_RD: begin
                o_rd_addr = r_head;
                n_state   = S_EMP_CLR;
            end
            S_EMP_CLR: begin
                n_p       = i_rd_link;
                o_lw_en   = 1'b1;
                o_lw_addr = r_head;
                o_lw_data = '0;
                n_state   = S_EMP_LOOP;
            end
            S_EMP_LOOP: begin
                if (r_steps == STEP_MAX || r_p == '0) begin
                    n_state = S_HEAD_RD;
                end else begin
                    o_rd_addr = r_p;
                    n_state   = S_EMP_FREE;
                end
            end
            S_EMP_FREE: begin
                n_c       = i_rd_link;
                o_lw_en   = 1'b1;
                o_lw_addr = r_p;
                o_lw_data = r_free;
                n_state   = S_EMP_LINK;
            end
            S_EMP_LINK: begin
                o_lw_en   = 1'b1;
                o_lw_addr = '0;
                o_lw_data = r_p;
                n_p       = r_c;
                n_steps   = steps_inc;
                n_state   = S_EMP_LOOP;
            end
            // list_empty flag
            S_HEAD_RD: begin
                o_rd_addr = r_head;
                n_state   = S_HEAD_CHK;
            end
            S_HEAD_CHK: begin
                n_empty = (i_rd_link == '0);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // shadow of link[0] follows every write to cell 0
    always_comb begin
        n_free = r_free;
        if (o_lw_en && o_lw_addr == '0) begin
            n_free = o_lw_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_init   <= '0;
            r_free   <= '0;
        end else begin
            r_state  <= n_state;
            r_init   <= n_init;
            r_free   <= n_free;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_head   <= n_head;
        r_key    <= n_key;
        r_p      <= n_p;
        r_c      <= n_c;
        r_steps  <= n_steps;
        r_status <= n_status;
        r_res    <= n_res;
        r_empty  <= n_empty;
    end

endmodule

`default_nettype wire

FILE: hdl/cursor_linked_list_manager.sv
// Commands are handled one at a time; chain walks take one link-memory read per
// cell (append, find, delete), and make empty frees each cell through the
// S_EMP_LOOP, S_EMP_FREE and S_EMP_LINK states; the sequencer returns to idle,
// ready for the next command, as the result moves to the output register.
// Reset: synchronous active-low i_rst_n; afterwards a sweep over all SPACE_SIZE
// cells builds the initial free chain, with o_s_tready low until it is done.
`default_nettype none

module cursor_linked_list_manager #(
    parameter int SPACE_SIZE = cllm_pkg::SPACE_SIZE_DEF,
    parameter int KEY_BITS   = cllm_pkg::KEY_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command stream
    input  wire logic        i_s_tvalid,
    output      logic        o_s_tready,
    // [2:0] command, [8:3] list_head, [14:9] position, [78:15] key, [79] zero
    input  wire logic [79:0] i_s_tdata,
    // result stream
    output      logic        o_m_tvalid,
    input  wire logic        i_m_tready,
    // [1:0] status, [7:2] result_position, [8] list_empty, [15:9] zero
    output      logic [15:0] o_m_tdata
);

    localparam int IW       = (SPACE_SIZE > 1) ? $clog2(SPACE_SIZE) : 1;
    localparam int POS_SPAN = 2 ** cllm_pkg::POS_BITS;

    // list_head / position wrap modulo SPACE_SIZE: small constant lookup
    function automatic logic [POS_SPAN-1:0][IW-1:0] build_wrap();
        logic [POS_SPAN-1:0][IW-1:0] t;
        for (int i = 0; i < POS_SPAN; i++) begin
            t[i] = IW'(i % SPACE_SIZE);
        end
        return t;
    endfunction

    localparam logic [POS_SPAN-1:0][IW-1:0] WRAP_TAB = build_wrap();

    logic [cllm_pkg::CMD_BITS-1:0]    in_cmd;
    logic [cllm_pkg::POS_BITS-1:0]    in_head_raw;
    logic [cllm_pkg::POS_BITS-1:0]    in_pos_raw;
    logic [cllm_pkg::IN_KEY_BITS-1:0] in_key_raw;
    logic [IW-1:0]                    in_head;
    logic [IW-1:0]                    in_pos;
    logic [KEY_BITS-1:0]              in_key;

    assign in_cmd      = i_s_tdata[2:0];
    assign in_head_raw = i_s_tdata[8:3];
    assign in_pos_raw  = i_s_tdata[14:9];
    assign in_key_raw  = i_s_tdata[78:15];
    assign in_head     = WRAP_TAB[in_head_raw];
    assign in_pos      = WRAP_TAB[in_pos_raw];
    assign in_key      = in_key_raw[KEY_BITS-1:0];   // only the low KEY_BITS count

    logic                 res_valid;
    logic                 res_ready;
    cllm_pkg::t_result    res;

    logic [IW-1:0]        rd_addr;
    logic [IW-1:0]        rd_link;
    logic [KEY_BITS-1:0]  rd_key;
    logic                 lw_en;
    logic [IW-1:0]        lw_addr;
    logic [IW-1:0]        lw_data;
    logic                 kw_en;
    logic [IW-1:0]        kw_addr;
    logic [KEY_BITS-1:0]  kw_data;

    cllm_ctrl #(
        .SPACE_SIZE (SPACE_SIZE),
        .KEY_BITS   (KEY_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_cmd       (in_cmd),
        .i_head      (in_head),
        .i_pos       (in_pos),
        .i_key       (in_key),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_rd_addr   (rd_addr),
        .i_rd_link   (rd_link),
        .i_rd_key    (rd_key),
        .o_lw_en     (lw_en),
        .o_lw_addr   (lw_addr),
        .o_lw_data   (lw_data),
        .o_kw_en     (kw_en),
        .o_kw_addr   (kw_addr),
        .o_kw_data   (kw_data)
    );

    cllm_store #(
        .SPACE_SIZE (SPACE_SIZE),
        .KEY_BITS   (KEY_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .o_rd_link (rd_link),
        .o_rd_key  (rd_key),
        .i_lw_en   (lw_en),
        .i_lw_addr (lw_addr),
        .i_lw_data (lw_data),
        .i_kw_en   (kw_en),
        .i_kw_addr (kw_addr),
        .i_kw_data (kw_data)
    );

    // Output register: the sequencer goes back to idle as soon as its result
    // is parked here, so the next command can start while this one waits.
    logic                 r_m_valid;
    cllm_pkg::t_result    r_m_res;

    assign res_ready = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_ready) begin
            r_m_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_m_res <= res;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {7'd0, r_m_res};

endmodule

`default_nettype wire
